// ===== hdl/vqnca_pkg.sv =====
// ----------------------------------------------------------------------------
// vqnca_pkg: shared types and constants
// Widths, depths, command codes and state encodings for the vector quantizer.
// ----------------------------------------------------------------------------
package vqnca_pkg;

  localparam int MaxCodewords = 64;
  localparam int MaxOrder     = 16;
  localparam int CwW          = $clog2(MaxCodewords);
  localparam int CompW        = $clog2(MaxOrder);
  localparam int AddrW        = CwW + CompW;
  localparam int Depth        = MaxCodewords * MaxOrder;
  localparam int DistW        = 36;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic REG_SIZE  = 1'b0;
  localparam logic REG_ORDER = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SEARCH = 8'b0000_0010,
    ST_ACC    = 8'b0000_0100,
    ST_ACCWR  = 8'b0000_1000,
    ST_RDWAIT = 8'b0001_0000,
    ST_RDOUT  = 8'b0010_0000,
    ST_CLEAR  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

endpackage

// ===== hdl/vqnca_ram.sv =====
// ----------------------------------------------------------------------------
// vqnca_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vqnca_ram #(
  parameter int Width = 16,
  parameter int Dep   = 64
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [$clog2(Dep)-1:0] waddr,
  input  logic [Width-1:0]       wdata,
  input  logic [$clog2(Dep)-1:0] raddr,
  output logic [Width-1:0]       rdata
);

  logic [Width-1:0] mem [Dep];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/vq_nearest_codeword_accumulate_top.sv =====
// ----------------------------------------------------------------------------
// vq_nearest_codeword_accumulate_top: nearest codeword search with accumulate
// Write, sample, readback and clear commands over a shared subtract-square unit.
// ----------------------------------------------------------------------------
// Write and non-final sample finish in idle; readback reads, then outputs; clear
//   walks all 1024 sum words, one sum word a cycle; a final sample searches
//   every codeword, one codeword component per cycle through one multiplier.
// One command at a time; busy is high until a final sample, readback or clear is finished.
// Synchronous reset starts an accumulator clearing pass while busy.
// Results show for one cycle on out_valid; the receiver cannot stall.
module vq_nearest_codeword_accumulate_top
  import vqnca_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_kind,
  input  logic [5:0]               in_entry,
  input  logic [3:0]               in_component,
  input  logic signed [15:0]       in_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [6:0]               cfg_data,
  output logic                     out_valid,
  output logic                     out_result_kind,
  output logic [5:0]               out_nearest_index,
  output logic [35:0]              out_squared_distance,
  output logic signed [31:0]       out_sum_value,
  output logic [15:0]              out_member_count
);

  state_t state_r, state_nxt;
  logic [6:0] size_r;
  logic [4:0] order_r;
  logic [CwW-1:0]   eff_last;
  logic [CompW-1:0] ord_last;

  always_comb begin
    if (size_r == 7'd0) eff_last = '0;
    else if (size_r > 7'(MaxCodewords)) eff_last = CwW'(MaxCodewords - 1);
    else eff_last = CwW'(size_r - 7'd1);
    if (order_r == 5'd0) ord_last = '0;
    else if (order_r > 5'(MaxOrder)) ord_last = CompW'(MaxOrder - 1);
    else ord_last = CompW'(order_r - 5'd1);
  end

  logic signed [15:0] samp_r [MaxOrder];

  // sequencer counters
  logic [CwW-1:0]   cw_r;
  logic [CompW-1:0] cp_r;
  logic             pv_r;        // read data valid for the pair issued last cycle
  logic [CwW-1:0]   pcw_r;
  logic [CompW-1:0] pcp_r;
  logic             plast_r;     // last component of a codeword
  logic             mv_r;        // product register valid
  logic             mlast_r;
  logic [CwW-1:0]   mcw_r;
  logic [32:0]      prod_r;
  logic [DistW+1:0] acc_r;
  logic [DistW+1:0] best_d_r;
  logic [CwW-1:0]   best_r;
  logic             have_best_r;
  logic             iss_done_r;
  logic [AddrW-1:0] clr_r;
  logic [CwW-1:0]   rd_entry_r;
  logic [CompW-1:0] rd_comp_r;

  // codeword RAM
  logic             cw_we;
  logic [15:0]      cw_rdata;
  logic [AddrW-1:0] cw_raddr;
  assign cw_we = !busy && start && in_kind == KIND_WRITE;
  assign cw_raddr = {cw_r, cp_r};

  vqnca_ram #(.Width(16), .Dep(Depth)) u_cw_ram (
    .clk(clk), .we(cw_we), .waddr({in_entry, in_component}),
    .wdata(in_value), .raddr(cw_raddr), .rdata(cw_rdata)
  );

  // sums RAM
  logic             sum_we;
  logic [AddrW-1:0] sum_waddr, sum_raddr;
  logic [31:0]      sum_wdata, sum_rdata;

  vqnca_ram #(.Width(32), .Dep(Depth)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_waddr),
    .wdata(sum_wdata), .raddr(sum_raddr), .rdata(sum_rdata)
  );

  // member count RAM
  logic             cnt_we;
  logic [CwW-1:0]   cnt_waddr, cnt_raddr;
  logic [15:0]      cnt_wdata, cnt_rdata;

  vqnca_ram #(.Width(16), .Dep(MaxCodewords)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr),
    .wdata(cnt_wdata), .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  // shared subtract-square
  logic signed [16:0] diff;
  logic signed [33:0] sq;
  assign diff = 17'(samp_r[pcp_r]) - 17'(signed'(cw_rdata));
  assign sq = diff * diff;

  logic [DistW+1:0] acc_sum;
  assign acc_sum = acc_r + (DistW+2)'(prod_r);

  // saturating accumulate of the sample into the winner's sums
  logic signed [32:0] sadd;
  assign sadd = 33'(signed'(sum_rdata)) + 33'(samp_r[cp_r]);

  always_comb begin
    sum_we = 1'b0;
    sum_waddr = {best_r, cp_r};
    sum_wdata = '0;
    sum_raddr = {best_r, cp_r};
    if (state_r == ST_CLEAR) begin
      sum_we = 1'b1;
      sum_waddr = clr_r;
    end else if (state_r == ST_ACCWR) begin
      sum_we = 1'b1;
      if (sadd > 33'sh0_7FFF_FFFF) sum_wdata = 32'h7FFF_FFFF;
      else if (sadd < -33'sh0_8000_0000) sum_wdata = 32'h8000_0000;
      else sum_wdata = sadd[31:0];
    end else if (state_r == ST_IDLE) begin
      sum_raddr = {in_entry, in_component};
    end else if (state_r == ST_RDWAIT) begin
      sum_raddr = {rd_entry_r, rd_comp_r};
    end
  end

  // count RAM holds best_r's count through the accumulate states
  always_comb begin
    cnt_we = 1'b0;
    cnt_waddr = best_r;
    cnt_wdata = '0;
    cnt_raddr = best_r;
    if (state_r == ST_CLEAR) begin
      cnt_we = 1'b1;
      cnt_waddr = clr_r[AddrW-1:CompW];
    end else if (state_r == ST_DONE) begin
      cnt_we = 1'b1;
      if (cnt_rdata == 16'hFFFF) cnt_wdata = cnt_rdata;
      else cnt_wdata = cnt_rdata + 16'd1;
    end else if (state_r == ST_IDLE) begin
      cnt_raddr = in_entry;
    end else if (state_r == ST_RDWAIT) begin
      cnt_raddr = rd_entry_r;
    end
  end

  assign busy = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;

  logic out_valid_nxt;
  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_kind)
            KIND_SAMPLE: if (in_component == ord_last) state_nxt = ST_SEARCH;
            KIND_READ:   state_nxt = ST_RDWAIT;
            KIND_CLEAR:  state_nxt = ST_CLEAR;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: if (iss_done_r && !pv_r && !mv_r) state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_ACCWR;
      ST_ACCWR:  if (cp_r == ord_last) state_nxt = ST_DONE; else state_nxt = ST_ACC;
      ST_DONE: begin
        state_nxt = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      ST_RDWAIT: state_nxt = ST_RDOUT;
      ST_RDOUT: begin
        state_nxt = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      ST_CLEAR: if (&clr_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      size_r <= 7'd1;
      order_r <= 5'd16;
      clr_r <= '0;
      out_valid <= 1'b0;
      pv_r <= 1'b0;
      mv_r <= 1'b0;
      iss_done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SIZE) size_r <= cfg_data;
        else order_r <= cfg_data[4:0];
      end
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      pv_r <= 1'b0;
      mv_r <= pv_r;
      if (state_r == ST_IDLE) begin
        iss_done_r <= 1'b0;
      end else if (state_r == ST_SEARCH && !iss_done_r) begin
        pv_r <= 1'b1;
        if (cp_r == ord_last && cw_r == eff_last) iss_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      if (in_kind == KIND_SAMPLE) samp_r[in_component] <= in_value;
      cw_r <= '0;
      cp_r <= '0;
      acc_r <= '0;
      have_best_r <= 1'b0;
      rd_entry_r <= in_entry;
      rd_comp_r <= in_component;
    end
    if (state_r == ST_SEARCH && !iss_done_r) begin
      pcw_r <= cw_r;
      pcp_r <= cp_r;
      plast_r <= cp_r == ord_last;
      if (cp_r == ord_last) begin
        cp_r <= '0;
        if (cw_r != eff_last) cw_r <= cw_r + 1'b1;
      end else begin
        cp_r <= cp_r + 1'b1;
      end
    end
    if (state_r == ST_SEARCH && iss_done_r && !pv_r && !mv_r) cp_r <= '0;
    if (pv_r) begin
      prod_r <= sq[32:0];
      mlast_r <= plast_r;
      mcw_r <= pcw_r;
    end
    if (mv_r) begin
      if (mlast_r) begin
        acc_r <= '0;
        if (!have_best_r || acc_sum < best_d_r) begin
          best_d_r <= acc_sum;
          best_r <= mcw_r;
        end
        have_best_r <= 1'b1;
      end else begin
        acc_r <= acc_sum;
      end
    end
    if (state_r == ST_ACCWR) cp_r <= cp_r + 1'b1;
    if (out_valid_nxt) begin
      if (state_r == ST_DONE) begin
        out_result_kind <= 1'b0;
        out_nearest_index <= best_r;
        if (|best_d_r[DistW+1:DistW]) out_squared_distance <= '1;
        else out_squared_distance <= best_d_r[DistW-1:0];
        out_sum_value <= '0;
        out_member_count <= '0;
      end else begin
        out_result_kind <= 1'b1;
        out_nearest_index <= '0;
        out_squared_distance <= '0;
        out_sum_value <= sum_rdata;
        out_member_count <= cnt_rdata;
      end
    end
  end

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result overlap");
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid)
    else $error("result during clear");
  a_out_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result longer than one cycle");

endmodule

// ===== test/vq_nearest_codeword_accumulate_top_tb.sv =====
// ----------------------------------------------------------------------------
// vq_nearest_codeword_accumulate_top_tb: self-checking bench for the quantizer
// Drives write, sample, readback and clear commands under several register
// settings and idle patterns; an in-bench predictor tracks codebook, sample
// buffer and saturating accumulators and checks every result beat in order.
// ----------------------------------------------------------------------------
module vq_nearest_codeword_accumulate_top_tb;
  import vqnca_pkg::*;

  localparam int CycleLimit = 6000000;
  localparam int SettleCycles = 1100;  // covers a full accumulator clearing pass
  localparam int FullRows = 8;         // codewords loaded in every component

  typedef struct {
    logic        kind;
    logic [5:0]  index;
    logic [35:0] sq_dist;
    logic signed [31:0] sum;
    logic [15:0] count;
  } vq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = KIND_WRITE;
  logic [5:0] in_entry = '0;
  logic [3:0] in_component = '0;
  logic signed [15:0] in_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_SIZE;
  logic [6:0] cfg_data = '0;
  logic out_valid;
  logic out_result_kind;
  logic [5:0] out_nearest_index;
  logic [35:0] out_squared_distance;
  logic signed [31:0] out_sum_value;
  logic [15:0] out_member_count;

  // predictor state
  logic signed [15:0] codebook [MaxCodewords][MaxOrder];
  logic signed [15:0] sample_buf [MaxOrder];
  logic signed [31:0] cluster_sum [MaxCodewords][MaxOrder];
  logic [15:0] member_cnt [MaxCodewords];
  int unsigned size_reg = 1;
  int unsigned order_reg = 16;

  vq_result_t pending_results[$];
  int errors = 0;
  int unsigned cycles = 0;
  int idle_pct = 0;

  vq_nearest_codeword_accumulate_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    vq_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: kind %0d idx %0d dist %0d sum %0d cnt %0d",
                 $time, out_result_kind, out_nearest_index, out_squared_distance,
                 out_sum_value, out_member_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_result_kind !== exp_r.kind || out_nearest_index !== exp_r.index ||
            out_squared_distance !== exp_r.sq_dist || out_sum_value !== exp_r.sum ||
            out_member_count !== exp_r.count) begin
          errors++;
          $display("%0t mismatch exp kind %0d idx %0d dist %0d sum %0d cnt %0d",
                   $time, exp_r.kind, exp_r.index, exp_r.sq_dist, exp_r.sum, exp_r.count);
          $display("%0t          got kind %0d idx %0d dist %0d sum %0d cnt %0d",
                   $time, out_result_kind, out_nearest_index, out_squared_distance,
                   out_sum_value, out_member_count);
        end
      end
    end
  end

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                 logic signed [15:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // update the predicted state for one accepted command, queue any result
  task automatic predict_command(logic [1:0] kind, logic [5:0] entry,
                                 logic [3:0] comp, logic signed [15:0] val);
    vq_result_t r;
    int unsigned n_cw, ord, best;
    longint unsigned d, best_d, diff;
    n_cw = (size_reg < 1) ? 1 : (size_reg > MaxCodewords) ? MaxCodewords : size_reg;
    ord = (order_reg < 1) ? 1 : (order_reg > MaxOrder) ? MaxOrder : order_reg;
    r = '{1'b0, '0, '0, '0, '0};
    case (kind)
      KIND_WRITE: codebook[entry][comp] = val;
      KIND_CLEAR: begin
        foreach (cluster_sum[i, j]) cluster_sum[i][j] = '0;
        foreach (member_cnt[i]) member_cnt[i] = '0;
      end
      KIND_READ: begin
        r.kind = 1'b1;
        r.sum = cluster_sum[entry][comp];
        r.count = member_cnt[entry];
        pending_results.push_back(r);
      end
      default: begin
        sample_buf[comp] = val;
        if (comp == ord - 1) begin
          best = 0;
          best_d = 0;
          for (int i = 0; i < n_cw; i++) begin
            d = 0;
            for (int l = 0; l < ord; l++) begin
              diff = longint'(sample_buf[l]) - longint'(codebook[i][l]);
              d += diff * diff;
            end
            if (i == 0 || d < best_d) begin
              best_d = d;
              best = i;
            end
          end
          for (int l = 0; l < ord; l++)
            cluster_sum[best][l] = sat_sum(cluster_sum[best][l], sample_buf[l]);
          if (member_cnt[best] != 16'hffff) member_cnt[best]++;
          r.index = best[5:0];
          r.sq_dist = (best_d > 64'hf_ffff_ffff) ? 36'hf_ffff_ffff : best_d[35:0];
          pending_results.push_back(r);
        end
      end
    endcase
  endtask

  // one command beat; start stays high when the next beat follows at once
  task automatic send_command(logic [1:0] kind, logic [5:0] entry,
                              logic [3:0] comp, logic signed [15:0] val);
    @(negedge clk);
    start = 1'b1;
    in_kind = kind;
    in_entry = entry;
    in_component = comp;
    in_value = val;
    do @(posedge clk); while (busy);
    predict_command(kind, entry, comp, val);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // registers change only with nothing in flight, including a long clear
  task automatic write_register(logic idx, logic [6:0] data);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SIZE) size_reg = data;
    else order_reg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_vector();
    int unsigned ord;
    ord = (order_reg < 1) ? 1 : (order_reg > MaxOrder) ? MaxOrder : order_reg;
    for (int l = 0; l < ord; l++)
      send_command(KIND_SAMPLE, '0, l[3:0], 16'($urandom));
  endtask

  // the first FullRows codewords get every component, the rest component 0;
  // searches stay within size <= FullRows or order 1
  task automatic test_load_codebook();
    for (int i = 0; i < MaxCodewords; i++)
      for (int l = 0; l < ((i < FullRows) ? MaxOrder : 1); l++)
        send_command(KIND_WRITE, i[5:0], l[3:0], 16'($urandom));
    for (int l = 0; l < MaxOrder; l++)
      send_command(KIND_SAMPLE, '0, l[3:0], 16'($urandom));
  endtask

  // extremes, equal-distance tie, readback corners, clear
  task automatic test_directed();
    write_register(REG_SIZE, 7'd4);
    write_register(REG_ORDER, 7'd2);
    send_command(KIND_WRITE, 6'd0, 4'd0, 16'sh7fff);
    send_command(KIND_WRITE, 6'd0, 4'd1, 16'sh7fff);
    send_command(KIND_WRITE, 6'd1, 4'd0, 16'sd5);
    send_command(KIND_WRITE, 6'd1, 4'd1, 16'sd5);
    send_command(KIND_WRITE, 6'd2, 4'd0, 16'sd5);
    send_command(KIND_WRITE, 6'd2, 4'd1, 16'sd5);
    send_command(KIND_WRITE, 6'd3, 4'd0, -16'sh8000);
    send_command(KIND_WRITE, 6'd3, 4'd1, -16'sh8000);
    send_command(KIND_SAMPLE, 6'd0, 4'd0, 16'sd5);
    send_command(KIND_SAMPLE, 6'd0, 4'd1, 16'sd5);
    send_command(KIND_SAMPLE, 6'd0, 4'd0, 16'sh7fff);
    send_command(KIND_SAMPLE, 6'd0, 4'd1, -16'sh8000);
    // position past the order is stored but starts nothing
    send_command(KIND_SAMPLE, 6'd0, 4'd15, -16'sh8000);
    send_command(KIND_READ, 6'd1, 4'd0, '0);
    send_command(KIND_READ, 6'd0, 4'd1, '0);
    send_command(KIND_READ, 6'd63, 4'd15, -1);
    send_command(KIND_CLEAR, 6'd63, 4'd15, -1);
    send_command(KIND_READ, 6'd1, 4'd0, '0);
    write_register(REG_ORDER, 7'd16);
    send_command(KIND_SAMPLE, 6'd63, 4'd15, 16'sh7fff);
  endtask

  // register values outside the usable range are clamped
  task automatic test_register_clamp();
    write_register(REG_SIZE, 7'd0);
    write_register(REG_ORDER, 7'd31);
    send_vector();
    write_register(REG_SIZE, 7'd127);
    write_register(REG_ORDER, 7'd0);
    send_vector();
    send_command(KIND_READ, 6'd0, 4'd0, '0);
  endtask

  // far-apart vectors pile up large negative sums in one cluster
  task automatic test_extreme_accumulate();
    write_register(REG_SIZE, 7'd1);
    write_register(REG_ORDER, 7'd1);
    send_command(KIND_CLEAR, '0, '0, '0);
    send_command(KIND_WRITE, 6'd0, 4'd0, 16'sh7fff);
    for (int k = 0; k < 24; k++)
      send_command(KIND_SAMPLE, '0, '0, -16'sh8000);
    send_command(KIND_READ, 6'd0, 4'd0, '0);
  endtask

  task automatic run_random(int n_items);
    int k;
    int unsigned pick;
    k = 0;
    while (k < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_vector();
        k += (order_reg < 1) ? 1 : (order_reg > MaxOrder) ? MaxOrder : order_reg;
      end else begin
        if (pick < 70) send_command(KIND_SAMPLE, 6'($urandom), 4'($urandom), 16'($urandom));
        else if (pick < 82) send_command(KIND_WRITE, 6'($urandom), 4'($urandom),
                                         16'($urandom));
        else if (pick < 98) send_command(KIND_READ, 6'($urandom), 4'($urandom),
                                         16'($urandom));
        else send_command(KIND_CLEAR, 6'($urandom), 4'($urandom), 16'($urandom));
        k++;
      end
    end
  endtask

  task automatic test_random_phases();
    int pct [4] = '{0, 76, 0, 12};
    for (int p = 0; p < 4; p++) begin
      idle_pct = pct[p];
      case (p)
        0: begin
          write_register(REG_SIZE, 7'(FullRows));
          write_register(REG_ORDER, 7'd16);
        end
        1: begin write_register(REG_SIZE, 7'd64); write_register(REG_ORDER, 7'd1); end
        default: begin
          write_register(REG_SIZE, 7'($urandom_range(1, FullRows)));
          write_register(REG_ORDER, 7'($urandom_range(1, 16)));
        end
      endcase
      run_random(80);
      wait_drained();  // sender holds off until all results are back
      run_random(80);
    end
    idle_pct = 0;
  endtask

  initial begin
    foreach (codebook[i, j]) codebook[i][j] = '0;
    foreach (sample_buf[i]) sample_buf[i] = '0;
    foreach (cluster_sum[i, j]) cluster_sum[i][j] = '0;
    foreach (member_cnt[i]) member_cnt[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_load_codebook();
    test_directed();
    test_register_clamp();
    test_random_phases();
    test_extreme_accumulate();
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== vq_nearest_codeword_accumulate_top.f =====
hdl/vqnca_pkg.sv
hdl/vqnca_ram.sv
hdl/vq_nearest_codeword_accumulate_top.sv
test/vq_nearest_codeword_accumulate_top_tb.sv
